// ===== hdl/lob_pkg.sv =====
// Package for the limit order book matcher.
// Holds the request/result structs, field widths and the sequencer states.
// No dependencies.
`default_nettype none
package lob_pkg;

  localparam int PRICE_W   = 32;
  localparam int QTY_W     = 32;
  localparam int BACKLOG_W = 39;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  typedef struct packed {
    logic               side;
    logic [PRICE_W-1:0] limit_price;
    logic [QTY_W-1:0]   quantity;
  } in_req_t;

  typedef struct packed {
    logic [QTY_W-1:0]     filled_quantity;
    logic [QTY_W-1:0]     rested_quantity;
    logic [QTY_W-1:0]     dropped_quantity;
    logic                 book_full;
    logic [BACKLOG_W-1:0] backlog_total;
  } out_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE,
    ST_PLACE
  } lob_state_t;

endpackage
`default_nettype wire

// ===== hdl/lob_book.sv =====
// One side of the book: price and amount memories, one write and one read port.
// Read data is registered. Depends on lob_pkg.
`default_nettype none
module lob_book #(
  parameter int DEPTH = 64,
  parameter int AMT_W = 32,
  parameter int IDX_W = 6
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [IDX_W-1:0]            wr_addr,
  input  wire logic [lob_pkg::PRICE_W-1:0] wr_price,
  input  wire logic [AMT_W-1:0]            wr_amt,
  input  wire logic [IDX_W-1:0]            rd_addr,
  output logic      [lob_pkg::PRICE_W-1:0] rd_price,
  output logic      [AMT_W-1:0]            rd_amt
);
  import lob_pkg::*;

  logic [PRICE_W-1:0] price_mem [DEPTH];
  logic [AMT_W-1:0]   amt_mem   [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      price_mem[wr_addr] <= wr_price;
      amt_mem[wr_addr]   <= wr_amt;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_price <= price_mem[rd_addr];
    rd_amt   <= amt_mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hdl/limit_order_book_matcher.sv =====
// Limit order book matcher, top level: sequencer, shared compare unit.
// Each order scans the opposite book for its best entry, decides, and on a full take moves
// the last entry into the hole and scans again; the place step then raises the result strobe.
// Throughput: one order at a time; busy drops with the strobe, next request can follow.
// Reset (rst_n low, synchronous) empties both books and clears the backlog.
// The result cannot be stalled; out_valid is high for exactly one cycle.
`default_nettype none
module limit_order_book_matcher #(
  parameter int BOOK_DEPTH = 64,
  parameter int QTY_WIDTH  = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire lob_pkg::in_req_t  in_req,
  output logic                   out_valid,
  output lob_pkg::out_rsp_t      out_rsp
);
  import lob_pkg::*;

  localparam int AMT_W = (QTY_WIDTH < QTY_W) ? QTY_WIDTH : QTY_W;
  localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
  localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

  lob_state_t          state_r, state_nxt;
  logic                side_r, side_nxt;
  logic [PRICE_W-1:0]  limit_r, limit_nxt;
  logic [AMT_W-1:0]    rem_r, rem_nxt;
  logic [AMT_W-1:0]    filled_r, filled_nxt;
  logic [BACKLOG_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                pend_r, pend_nxt;
  logic [IDX_W-1:0]    pidx_r, pidx_nxt;
  logic [IDX_W-1:0]    best_idx_r, best_idx_nxt;
  logic [PRICE_W-1:0]  best_p_r, best_p_nxt;
  logic [AMT_W-1:0]    best_a_r, best_a_nxt;
  logic [CNT_W-1:0]    bid_cnt_r, bid_cnt_nxt;
  logic [CNT_W-1:0]    ask_cnt_r, ask_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_rsp_t            out_r, out_nxt;

  // book ports
  logic [IDX_W-1:0]   rd_addr;
  logic               opp_we, own_we;
  logic [IDX_W-1:0]   opp_waddr, own_waddr;
  logic [PRICE_W-1:0] opp_wprice;
  logic [AMT_W-1:0]   opp_wamt;
  logic [PRICE_W-1:0] bid_rp, ask_rp, opp_rp;
  logic [AMT_W-1:0]   bid_ra, ask_ra, opp_ra;
  logic [CNT_W-1:0]   opp_cnt, own_cnt, opp_last;

  assign opp_cnt  = side_r ? bid_cnt_r : ask_cnt_r;
  assign own_cnt  = side_r ? ask_cnt_r : bid_cnt_r;
  assign opp_last = opp_cnt - 1'b1;
  assign opp_rp   = side_r ? bid_rp : ask_rp;
  assign opp_ra   = side_r ? bid_ra : ask_ra;
  assign own_waddr = own_cnt[IDX_W-1:0];

  lob_book #(.DEPTH(BOOK_DEPTH), .AMT_W(AMT_W), .IDX_W(IDX_W)) u_bid (
    .clk      (clk),
    .wr_en    (side_r ? opp_we : own_we),
    .wr_addr  (side_r ? opp_waddr : own_waddr),
    .wr_price (side_r ? opp_wprice : limit_r),
    .wr_amt   (side_r ? opp_wamt : rem_r),
    .rd_addr  (rd_addr),
    .rd_price (bid_rp),
    .rd_amt   (bid_ra)
  );

  lob_book #(.DEPTH(BOOK_DEPTH), .AMT_W(AMT_W), .IDX_W(IDX_W)) u_ask (
    .clk      (clk),
    .wr_en    (side_r ? own_we : opp_we),
    .wr_addr  (side_r ? own_waddr : opp_waddr),
    .wr_price (side_r ? limit_r : opp_wprice),
    .wr_amt   (side_r ? rem_r : opp_wamt),
    .rd_addr  (rd_addr),
    .rd_price (ask_rp),
    .rd_amt   (ask_ra)
  );

  // shared compare unit: scan ranking and crossing test
  logic [PRICE_W-1:0] cmp_a, cmp_b;
  logic               cmp_lt, cmp_gt;
  assign cmp_a  = (state_r == ST_SCAN) ? opp_rp : best_p_r;
  assign cmp_b  = (state_r == ST_SCAN) ? best_p_r : limit_r;
  assign cmp_lt = cmp_a < cmp_b;
  assign cmp_gt = cmp_a > cmp_b;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bid_cnt_r   <= '0;
      ask_cnt_r   <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bid_cnt_r   <= bid_cnt_nxt;
      ask_cnt_r   <= ask_cnt_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    side_r     <= side_nxt;
    limit_r    <= limit_nxt;
    rem_r      <= rem_nxt;
    filled_r   <= filled_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    best_idx_r <= best_idx_nxt;
    best_p_r   <= best_p_nxt;
    best_a_r   <= best_a_nxt;
    out_r      <= out_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    side_nxt      = side_r;
    limit_nxt     = limit_r;
    rem_nxt       = rem_r;
    filled_nxt    = filled_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    best_idx_nxt  = best_idx_r;
    best_p_nxt    = best_p_r;
    best_a_nxt    = best_a_r;
    bid_cnt_nxt   = bid_cnt_r;
    ask_cnt_nxt   = ask_cnt_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_addr       = idx_r[IDX_W-1:0];
    opp_we        = 1'b0;
    own_we        = 1'b0;
    opp_waddr     = best_idx_r;
    opp_wprice    = best_p_r;
    opp_wamt      = best_a_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          side_nxt   = in_req.side;
          limit_nxt  = in_req.limit_price;
          rem_nxt    = in_req.quantity[AMT_W-1:0];
          filled_nxt = '0;
          idx_nxt    = '0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (idx_r == '0 && !pend_r && (rem_r == '0 || opp_cnt == '0)) begin
          state_nxt = ST_PLACE;
        end else begin
          // issue next read
          if (idx_r < opp_cnt) begin
            pend_nxt = 1'b1;
            pidx_nxt = idx_r[IDX_W-1:0];
            idx_nxt  = idx_r + 1'b1;
          end else if (!pend_r) begin
            state_nxt = ST_DECIDE;
          end
          // rank the returned entry
          if (pend_r) begin
            if (pidx_r == '0 || (side_r == SIDE_SELL ? cmp_gt : cmp_lt)) begin
              best_idx_nxt = pidx_r;
              best_p_nxt   = opp_rp;
              best_a_nxt   = opp_ra;
            end
          end
        end
      end
      ST_DECIDE: begin
        rd_addr = opp_last[IDX_W-1:0];
        if (side_r == SIDE_SELL ? cmp_lt : cmp_gt) begin
          state_nxt = ST_PLACE;
        end else if (best_a_r > rem_r) begin
          // partial take: entry keeps its remainder
          opp_we     = 1'b1;
          opp_wamt   = best_a_r - rem_r;
          sum_nxt    = sum_r - BACKLOG_W'(rem_r);
          filled_nxt = filled_r + rem_r;
          rem_nxt    = '0;
          state_nxt  = ST_PLACE;
        end else begin
          // full take: last entry moves into the hole
          sum_nxt    = sum_r - BACKLOG_W'(best_a_r);
          filled_nxt = filled_r + best_a_r;
          rem_nxt    = rem_r - best_a_r;
          state_nxt  = ST_MOVE;
        end
      end
      ST_MOVE: begin
        opp_we     = 1'b1;
        opp_wprice = opp_rp;
        opp_wamt   = opp_ra;
        if (side_r == SIDE_SELL) bid_cnt_nxt = opp_last;
        else                     ask_cnt_nxt = opp_last;
        idx_nxt   = '0;
        state_nxt = ST_SCAN;
      end
      ST_PLACE: begin
        out_nxt.filled_quantity  = QTY_W'(filled_r);
        out_nxt.rested_quantity  = '0;
        out_nxt.dropped_quantity = '0;
        out_nxt.book_full        = 1'b0;
        if (rem_r != '0) begin
          if (own_cnt < CNT_W'(BOOK_DEPTH)) begin
            own_we  = 1'b1;
            sum_nxt = sum_r + BACKLOG_W'(rem_r);
            out_nxt.rested_quantity = QTY_W'(rem_r);
            if (side_r == SIDE_SELL) ask_cnt_nxt = ask_cnt_r + 1'b1;
            else                     bid_cnt_nxt = bid_cnt_r + 1'b1;
          end else begin
            out_nxt.dropped_quantity = QTY_W'(rem_r);
            out_nxt.book_full        = 1'b1;
          end
        end
        out_nxt.backlog_total = sum_nxt;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  // checks
  a_out_after_place: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_PLACE)) else $error("result without place step");
  a_bid_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bid_cnt_r <= CNT_W'(BOOK_DEPTH)) else $error("bid count overflow");
  a_ask_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ask_cnt_r <= CNT_W'(BOOK_DEPTH)) else $error("ask count overflow");
  a_full_no_rest: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.book_full |-> out_rsp.rested_quantity == '0)
    else $error("rested while full");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("request not taken");

endmodule
`default_nettype wire
